FILE: design/tcw_pkg.sv
// shared constants, types and helpers for the text console writer
// no dependencies; used by the writer unit and the checker
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CUR_W  = 11;
  localparam int PROD_W = 12;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;
  localparam logic [7:0] RESET_COLOR    = 8'd7;

  typedef enum logic [2:0] {
    OP_PUT_CHAR = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_SET_CUR  = 3'd2,
    OP_HEX      = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_HEX,
    S_SCROLL,
    S_FILL,
    S_RDWAIT,
    S_EMIT
  } state_t;

  // upper-case hex glyph of one nibble
  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = 8'h30 + {4'd0, nib};
    end else begin
      g = 8'h37 + {4'd0, nib};
    end
    return g;
  endfunction

endpackage

FILE: design/tcw_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/text_console_writer_unit.sv
// text console writer: cell grid in one ram, write position, cursor latch
// depends on tcw_pkg and tcw_ram
//
// steps: set cursor and unknown ops go straight to the result, read cell waits
// on the ram read, put char and each hex digit pass the put state; a scroll
// moves (ROWS-1)*COLUMNS and blanks COLUMNS cells; clear writes ROWS*COLUMNS
// throughput: one transaction at a time; the next is taken while a result waits
// reset (rst_n low, synchronous): position, cursor and color go to reset values,
// then a clearing pass zeroes all ROWS*COLUMNS cells, in_tready low
module text_console_writer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: text_color
  input  logic                            cfg_wr_en,
  input  logic [7:0]                      cfg_wr_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code[7:0], target_row[15:8], target_col[23:16], hex_value[55:24],
  // hex_digits[59:56], cell_index[70:60], zero pad[71]
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [2:0]                      in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // write_row[4:0], write_col[11:5], cursor_pos[22:12], cell_data[38:23],
  // zero pad[39]
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = tcw_pkg::ADDR_W;

  // input field unpacking
  logic [7:0]  in_char;
  logic [7:0]  in_trow;
  logic [7:0]  in_tcol;
  logic [31:0] in_hval;
  logic [3:0]  in_hdig;
  logic [10:0] in_idx;
  tcw_pkg::op_t in_op;

  assign in_char = in_tdata[7:0];
  assign in_trow = in_tdata[15:8];
  assign in_tcol = in_tdata[23:16];
  assign in_hval = in_tdata[55:24];
  assign in_hdig = in_tdata[59:56];
  assign in_idx  = in_tdata[70:60];
  assign in_op   = tcw_pkg::op_t'(in_tuser);

  // control state
  tcw_pkg::state_t state_r, state_nxt;
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [7:0]                 color_r;
  logic [AW-1:0]              cnt_r, cnt_nxt;
  logic [3:0]                 hex_left_r, hex_left_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;

  // payload
  logic [AW-1:0]                    pend_addr_r, pend_addr_nxt;
  logic [7:0]                       ch_r, ch_nxt;
  logic [31:0]                      hex_r, hex_nxt;
  logic [tcw_pkg::CELL_W-1:0]       cell_r, cell_nxt;
  logic [tcw_pkg::CELL_W-1:0]       fill_r, fill_nxt;
  logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  // ram port
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // linear address of the write position
  logic [AW-1:0] pos_addr;
  assign pos_addr = AW'(row_r) * AW'(tcw_pkg::COLUMNS) + AW'(col_r);

  logic [tcw_pkg::CELL_W-1:0] blank;
  assign blank = {color_r, tcw_pkg::CH_SPACE};

  // set cursor clamping
  logic [tcw_pkg::ROW_W-1:0]  trow_cl;
  logic [tcw_pkg::COL_W-1:0]  tcol_cl;
  logic [tcw_pkg::PROD_W-1:0] cur_prod;

  always_comb begin
    if (in_trow >= 8'(tcw_pkg::ROWS)) begin
      trow_cl = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    end else begin
      trow_cl = in_trow[tcw_pkg::ROW_W-1:0];
    end
    if (in_tcol >= 8'(tcw_pkg::COLUMNS)) begin
      tcol_cl = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    end else begin
      tcol_cl = in_tcol[tcw_pkg::COL_W-1:0];
    end
    cur_prod = tcw_pkg::PROD_W'(trow_cl) * tcw_pkg::PROD_W'(tcw_pkg::COLUMNS)
             + tcw_pkg::PROD_W'(tcol_cl);
  end

  // hex digit count, capped at eight
  logic [3:0] hdig_cl;
  assign hdig_cl = (in_hdig > tcw_pkg::MAX_HEX_DIGITS) ? tcw_pkg::MAX_HEX_DIGITS : in_hdig;

  logic in_accept;
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == tcw_pkg::S_IDLE);

  logic next_is_hex;
  assign next_is_hex = (hex_left_r != 4'd0);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    cursor_nxt     = cursor_r;
    cnt_nxt        = cnt_r;
    hex_left_nxt   = hex_left_r;
    pend_valid_nxt = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    ch_nxt         = ch_r;
    hex_nxt        = hex_r;
    cell_nxt       = cell_r;
    fill_nxt       = fill_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = cnt_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // scroll move: data read last cycle lands one row up
    if (pend_valid_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
        if (cnt_r == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      tcw_pkg::S_IDLE: begin
        if (in_accept) begin
          cell_nxt     = '0;
          hex_left_nxt = 4'd0;
          case (in_op)
            tcw_pkg::OP_PUT_CHAR: begin
              ch_nxt    = in_char;
              state_nxt = tcw_pkg::S_PUT;
            end
            tcw_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              cnt_nxt   = '0;
              fill_nxt  = blank;
              state_nxt = tcw_pkg::S_FILL;
            end
            tcw_pkg::OP_SET_CUR: begin
              row_nxt    = trow_cl;
              col_nxt    = tcol_cl;
              cursor_nxt = cur_prod[tcw_pkg::CUR_W-1:0];
              state_nxt  = tcw_pkg::S_EMIT;
            end
            tcw_pkg::OP_HEX: begin
              // align the first digit to the top nibble
              hex_nxt      = in_hval << {3'(4'd8 - hdig_cl), 2'b00};
              hex_left_nxt = hdig_cl;
              state_nxt    = (hdig_cl == 4'd0) ? tcw_pkg::S_EMIT : tcw_pkg::S_HEX;
            end
            tcw_pkg::OP_READ: begin
              if ({1'b0, in_idx} < 12'(tcw_pkg::CELL_COUNT)) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_idx);
                state_nxt = tcw_pkg::S_RDWAIT;
              end else begin
                state_nxt = tcw_pkg::S_EMIT;
              end
            end
            default: begin
              state_nxt = tcw_pkg::S_EMIT;
            end
          endcase
        end
      end

      tcw_pkg::S_HEX: begin
        ch_nxt       = tcw_pkg::hex_glyph(hex_r[31:28]);
        hex_nxt      = {hex_r[27:0], 4'd0};
        hex_left_nxt = hex_left_r - 4'd1;
        state_nxt    = tcw_pkg::S_PUT;
      end

      tcw_pkg::S_PUT: begin
        state_nxt = next_is_hex ? tcw_pkg::S_HEX : tcw_pkg::S_EMIT;
        case (ch_r)
          tcw_pkg::CH_NEWLINE: begin
            col_nxt = '0;
            if (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
              cnt_nxt   = '0;
              state_nxt = tcw_pkg::S_SCROLL;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
          tcw_pkg::CH_RETURN: begin
            col_nxt = '0;
          end
          tcw_pkg::CH_BACKSPACE: begin
            // previous cell is one linear address back, across rows too
            if (row_r != '0 || col_r != '0) begin
              mem_we    = 1'b1;
              mem_waddr = pos_addr - AW'(1);
              mem_wdata = blank;
              if (col_r == '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
              end else begin
                col_nxt = col_r - 1'b1;
              end
            end
          end
          default: begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
            mem_wdata = {color_r, ch_r};
            if (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
              col_nxt = '0;
              if (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::S_SCROLL;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        endcase
      end

      tcw_pkg::S_SCROLL: begin
        // read one row ahead, write back next cycle; sources stay ahead of writes
        if (cnt_r < AW'(tcw_pkg::MOVE_COUNT)) begin
          mem_re         = 1'b1;
          mem_raddr      = cnt_r + AW'(tcw_pkg::COLUMNS);
          pend_valid_nxt = 1'b1;
          pend_addr_nxt  = cnt_r;
          cnt_nxt        = cnt_r + AW'(1);
        end else if (!pend_valid_r) begin
          // bottom row blanking starts at MOVE_COUNT
          fill_nxt  = blank;
          state_nxt = tcw_pkg::S_FILL;
        end
      end

      tcw_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = fill_r;
        if (cnt_r == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = next_is_hex ? tcw_pkg::S_HEX : tcw_pkg::S_EMIT;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      tcw_pkg::S_RDWAIT: begin
        cell_nxt  = mem_rdata;
        state_nxt = tcw_pkg::S_EMIT;
      end

      tcw_pkg::S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, cell_r, cursor_r, col_r, row_r};
          state_nxt      = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::S_INIT;
      row_r        <= '0;
      col_r        <= '0;
      cursor_r     <= '0;
      color_r      <= tcw_pkg::RESET_COLOR;
      cnt_r        <= '0;
      hex_left_r   <= '0;
      pend_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      cursor_r     <= cursor_nxt;
      cnt_r        <= cnt_nxt;
      hex_left_r   <= hex_left_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    ch_r        <= ch_nxt;
    hex_r       <= hex_nxt;
    cell_r      <= cell_nxt;
    fill_r      <= fill_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: design/tcw_checker.sv
// port-level checks for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_unit
module tcw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during reset clearing pass");

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken before the first finished");

  // reported position stays on the grid
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] < tcw_pkg::ROWS) &&
                   (out_tdata[11:5] < tcw_pkg::COLUMNS) &&
                   (out_tdata[22:12] < tcw_pkg::CELL_COUNT))
    else $error("write position or cursor off the grid");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
